@@ rtl/zbsu_pkg.sv @@
`timescale 1ns / 1ps

package zbsu_pkg;

   // Opcode groups by the low three bits of the opcode.
   localparam logic [2:0] GRP_RET_CC   = 3'd0;
   localparam logic [2:0] GRP_POP_MISC = 3'd1;
   localparam logic [2:0] GRP_JP_CC    = 3'd2;
   localparam logic [2:0] GRP_MISC3    = 3'd3;
   localparam logic [2:0] GRP_CALL_CC  = 3'd4;
   localparam logic [2:0] GRP_PUSH_MSC = 3'd5;
   localparam logic [2:0] GRP_ALU_IMM  = 3'd6;
   localparam logic [2:0] GRP_RST      = 3'd7;

   // Bits 5..3 of the opcode in the miscellaneous group ending in 3.
   localparam logic [2:0] SUB3_JP      = 3'd0;
   localparam logic [2:0] SUB3_PFX_CB  = 3'd1;
   localparam logic [2:0] SUB3_OUT     = 3'd2;
   localparam logic [2:0] SUB3_IN      = 3'd3;
   localparam logic [2:0] SUB3_EX_SPHL = 3'd4;
   localparam logic [2:0] SUB3_EX_DEHL = 3'd5;
   localparam logic [2:0] SUB3_DI      = 3'd6;
   localparam logic [2:0] SUB3_EI      = 3'd7;

   // Bits 5..4 of the opcode for the ones ending in 9 and the pair field.
   localparam logic [1:0] SUB9_RET     = 2'd0;
   localparam logic [1:0] SUB9_EXX     = 2'd1;
   localparam logic [1:0] SUB9_JP_HL   = 2'd2;
   localparam logic [1:0] SUB9_LD_SPHL = 2'd3;

   localparam logic [1:0] PAIR_BC      = 2'd0;
   localparam logic [1:0] PAIR_DE      = 2'd1;
   localparam logic [1:0] PAIR_HL      = 2'd2;
   localparam logic [1:0] PAIR_AF      = 2'd3;

   // Condition flag selected by bits 5..4 of the opcode.
   localparam logic [1:0] CC_ZERO      = 2'd0;
   localparam logic [1:0] CC_CARRY     = 2'd1;
   localparam logic [1:0] CC_PARITY    = 2'd2;
   localparam logic [1:0] CC_SIGN      = 2'd3;

   localparam logic [1:0] PORT_NONE    = 2'd0;
   localparam logic [1:0] PORT_OUT     = 2'd1;
   localparam logic [1:0] PORT_IN      = 2'd2;

   localparam logic [4:0] T_STATES_4   = 5'd4;
   localparam logic [4:0] T_STATES_5   = 5'd5;
   localparam logic [4:0] T_STATES_6   = 5'd6;
   localparam logic [4:0] T_STATES_10  = 5'd10;
   localparam logic [4:0] T_STATES_11  = 5'd11;
   localparam logic [4:0] T_STATES_17  = 5'd17;
   localparam logic [4:0] T_STATES_19  = 5'd19;

   localparam logic [15:0] SP_RESET    = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  mode;
      logic [15:0] imm_word;
      logic [15:0] stack_word;
      logic [7:0]  port_read_data;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        mem_write_enable;
      logic [15:0] mem_write_address;
      logic [15:0] mem_write_word;
      logic [1:0]  port_kind;
      logic [15:0] port_address;
      logic [7:0]  port_write_data;
      logic [4:0]  cycle_count;
      logic        unhandled;
      logic        ei_executed;
   } rsp_type;

endpackage

@@ rtl/zbsu_chan_if.sv @@
`timescale 1ns / 1ps

interface zbsu_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/z80_branch_stack_unit_core.sv @@
`timescale 1ns / 1ps

// Channel   Interface      Direction  Word
// req_chan  zbsu_chan_if   in         opcode, immediate, word at SP, port read byte
// rsp_chan  zbsu_chan_if   out        next PC, stack write, port access, T-states
//
// An accepted word is held in the input register and is executed from there into the
// result register; one instruction every cycle while the result is not stalled.
// The register file updates as an instruction leaves the input register, so each
// instruction sees the state its predecessor left.
// Reset is synchronous: PC and the pairs clear, SP goes to FFFF, both stages empty.
// A stalled result holds the input stage; the input stays ready while it is empty.

module z80_branch_stack_unit_core
   import zbsu_pkg::*;
(
   input logic          clock,
   input logic          reset,
   zbsu_chan_if.sink    req_chan,
   zbsu_chan_if.source  rsp_chan
);

   logic        in_valid_ff;
   req_type     in_word_ff;
   logic        out_valid_ff;
   rsp_type     out_word_ff;
   rsp_type     out_word_in;

   logic [15:0] pc_ff, pc_in;
   logic [15:0] sp_ff, sp_in;
   logic [15:0] af_ff, af_in;
   logic [15:0] bc_ff, bc_in;
   logic [15:0] de_ff, de_in;
   logic [15:0] hl_ff, hl_in;
   logic [15:0] bc2_ff, bc2_in;
   logic [15:0] de2_ff, de2_in;
   logic [15:0] hl2_ff, hl2_in;
   logic        iff1_ff, iff1_in;
   logic        iff2_ff, iff2_in;

   logic        execute;
   logic [7:0]  op;
   logic [2:0]  cc;
   logic        flag_bit;
   logic        cond_met;
   logic [15:0] pc_plus1;
   logic [15:0] pc_plus2;
   logic [15:0] pc_plus3;
   logic [15:0] pair_val;
   logic        push;
   logic [15:0] push_val;
   logic [15:0] port_addr;

   assign execute        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || execute;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   assign op        = in_word_ff.mode;
   assign cc        = op[5:3];
   assign pc_plus1  = pc_ff + 16'd1;
   assign pc_plus2  = pc_ff + 16'd2;
   assign pc_plus3  = pc_ff + 16'd3;
   assign port_addr = {af_ff[15:8], in_word_ff.imm_word[7:0]};

   always_comb begin
      case (cc[2:1])
         CC_ZERO:   flag_bit = af_ff[6];
         CC_CARRY:  flag_bit = af_ff[0];
         CC_PARITY: flag_bit = af_ff[2];
         CC_SIGN:   flag_bit = af_ff[7];
         default:   flag_bit = af_ff[7];
      endcase
      cond_met = cc[0] ? flag_bit : !flag_bit;
   end

   always_comb begin
      case (op[5:4])
         PAIR_BC: pair_val = bc_ff;
         PAIR_DE: pair_val = de_ff;
         PAIR_HL: pair_val = hl_ff;
         PAIR_AF: pair_val = af_ff;
         default: pair_val = af_ff;
      endcase
   end

   always_comb begin
      sp_in  = sp_ff;
      af_in  = af_ff;
      bc_in  = bc_ff;
      de_in  = de_ff;
      hl_in  = hl_ff;
      bc2_in = bc2_ff;
      de2_in = de2_ff;
      hl2_in = hl2_ff;
      iff1_in = iff1_ff;
      iff2_in = iff2_ff;
      push     = 1'b0;
      push_val = 16'd0;

      out_word_in = '0;
      out_word_in.next_pc     = pc_plus1;
      out_word_in.port_kind   = PORT_NONE;
      out_word_in.cycle_count = T_STATES_4;

      if (op[7:6] != 2'b11) begin
         out_word_in.unhandled = 1'b1;
         out_word_in.next_pc   = pc_ff;
      end else begin
         case (op[2:0])
            GRP_RET_CC: begin
               if (cond_met) begin
                  out_word_in.next_pc     = in_word_ff.stack_word;
                  sp_in                   = sp_ff + 16'd2;
                  out_word_in.cycle_count = T_STATES_11;
               end else begin
                  out_word_in.cycle_count = T_STATES_5;
               end
            end
            GRP_POP_MISC: begin
               if (!op[3]) begin
                  case (op[5:4])
                     PAIR_BC: bc_in = in_word_ff.stack_word;
                     PAIR_DE: de_in = in_word_ff.stack_word;
                     PAIR_HL: hl_in = in_word_ff.stack_word;
                     default: af_in = in_word_ff.stack_word;
                  endcase
                  sp_in                   = sp_ff + 16'd2;
                  out_word_in.cycle_count = T_STATES_10;
               end else begin
                  case (op[5:4])
                     SUB9_RET: begin
                        out_word_in.next_pc     = in_word_ff.stack_word;
                        sp_in                   = sp_ff + 16'd2;
                        out_word_in.cycle_count = T_STATES_10;
                     end
                     SUB9_EXX: begin
                        bc_in  = bc2_ff;
                        bc2_in = bc_ff;
                        de_in  = de2_ff;
                        de2_in = de_ff;
                        hl_in  = hl2_ff;
                        hl2_in = hl_ff;
                     end
                     SUB9_JP_HL: begin
                        out_word_in.next_pc = hl_ff;
                     end
                     default: begin
                        sp_in                   = hl_ff;
                        out_word_in.cycle_count = T_STATES_6;
                     end
                  endcase
               end
            end
            GRP_JP_CC: begin
               out_word_in.next_pc     = cond_met ? in_word_ff.imm_word : pc_plus3;
               out_word_in.cycle_count = T_STATES_10;
            end
            GRP_MISC3: begin
               case (cc)
                  SUB3_JP: begin
                     out_word_in.next_pc     = in_word_ff.imm_word;
                     out_word_in.cycle_count = T_STATES_10;
                  end
                  SUB3_OUT: begin
                     out_word_in.next_pc         = pc_plus2;
                     out_word_in.port_kind       = PORT_OUT;
                     out_word_in.port_address    = port_addr;
                     out_word_in.port_write_data = af_ff[15:8];
                     out_word_in.cycle_count     = T_STATES_11;
                  end
                  SUB3_IN: begin
                     out_word_in.next_pc      = pc_plus2;
                     out_word_in.port_kind    = PORT_IN;
                     out_word_in.port_address = port_addr;
                     af_in = {in_word_ff.port_read_data, af_ff[7:0]};
                     out_word_in.cycle_count  = T_STATES_11;
                  end
                  SUB3_EX_SPHL: begin
                     out_word_in.mem_write_enable  = 1'b1;
                     out_word_in.mem_write_address = sp_ff;
                     out_word_in.mem_write_word    = hl_ff;
                     hl_in                         = in_word_ff.stack_word;
                     out_word_in.cycle_count       = T_STATES_19;
                  end
                  SUB3_EX_DEHL: begin
                     de_in = hl_ff;
                     hl_in = de_ff;
                  end
                  SUB3_DI: begin
                     iff1_in = 1'b0;
                     iff2_in = 1'b0;
                  end
                  SUB3_EI: begin
                     iff1_in = 1'b1;
                     iff2_in = 1'b1;
                     out_word_in.ei_executed = 1'b1;
                  end
                  default: begin
                     // The CB prefix is not executed here.
                     out_word_in.unhandled = 1'b1;
                     out_word_in.next_pc   = pc_ff;
                  end
               endcase
            end
            GRP_CALL_CC: begin
               if (cond_met) begin
                  push                    = 1'b1;
                  push_val                = pc_plus3;
                  out_word_in.next_pc     = in_word_ff.imm_word;
                  out_word_in.cycle_count = T_STATES_17;
               end else begin
                  out_word_in.next_pc     = pc_plus3;
                  out_word_in.cycle_count = T_STATES_10;
               end
            end
            GRP_PUSH_MSC: begin
               if (!op[3]) begin
                  push                    = 1'b1;
                  push_val                = pair_val;
                  out_word_in.cycle_count = T_STATES_11;
               end else if (op[5:4] == SUB9_RET) begin
                  // Plain CALL shares its field with RET in the group ending in 9.
                  push                    = 1'b1;
                  push_val                = pc_plus3;
                  out_word_in.next_pc     = in_word_ff.imm_word;
                  out_word_in.cycle_count = T_STATES_17;
               end else begin
                  out_word_in.unhandled = 1'b1;
                  out_word_in.next_pc   = pc_ff;
               end
            end
            GRP_ALU_IMM: begin
               out_word_in.unhandled = 1'b1;
               out_word_in.next_pc   = pc_ff;
            end
            default: begin
               push                    = 1'b1;
               push_val                = pc_plus1;
               out_word_in.next_pc     = {10'd0, op[5:3], 3'd0};
               out_word_in.cycle_count = T_STATES_11;
            end
         endcase
      end

      if (push) begin
         sp_in                         = sp_ff - 16'd2;
         out_word_in.mem_write_enable  = 1'b1;
         out_word_in.mem_write_address = sp_ff - 16'd2;
         out_word_in.mem_write_word    = push_val;
      end
      pc_in = out_word_in.next_pc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff   <= 16'd0;
         sp_ff   <= SP_RESET;
         af_ff   <= 16'd0;
         bc_ff   <= 16'd0;
         de_ff   <= 16'd0;
         hl_ff   <= 16'd0;
         bc2_ff  <= 16'd0;
         de2_ff  <= 16'd0;
         hl2_ff  <= 16'd0;
         iff1_ff <= 1'b0;
         iff2_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (execute) begin
            out_valid_ff <= 1'b1;
            pc_ff   <= pc_in;
            sp_ff   <= sp_in;
            af_ff   <= af_in;
            bc_ff   <= bc_in;
            de_ff   <= de_in;
            hl_ff   <= hl_in;
            bc2_ff  <= bc2_in;
            de2_ff  <= de2_in;
            hl2_ff  <= hl2_in;
            iff1_ff <= iff1_in;
            iff2_ff <= iff2_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         in_word_ff <= req_chan.payload;
      end
      if (execute) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule
